// ===== sv/mwrle_pkg.sv =====
// Shared types, codes and helpers for the multi-width run-length pixel decoder.
package mwrle_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned MODE_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAW   = 3'd0,
    MODE_RLE8  = 3'd1,
    MODE_RLE12 = 3'd2,
    MODE_RLE16 = 3'd3,
    MODE_RLE24 = 3'd4
  } mode_e;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_RLE8;

  // Register index is paddr[2]; only one register exists.
  localparam logic REG_MODE = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_RUN     = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  localparam logic [7:0] RUN_HDR_MAX = 8'h7f;

  typedef logic [23:0] pixel_t;
  typedef logic [7:0]  count_t;

  typedef struct packed {
    logic   valid;
    pixel_t pixel;
    count_t count;
  } res_t;

  // 4-bit channel scaled by 17 is the nibble repeated in both halves.
  function automatic logic [7:0] scale17(input logic [3:0] nib);
    return {nib, nib};
  endfunction

endpackage

// ===== sv/mwrle_cfg.sv =====
// APB-style register port holding the decode mode.
module mwrle_cfg import mwrle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [MODE_W-1:0]  mode_o,
  output logic               clear_o
);

  logic [MODE_W-1:0] mode_q, mode_d;
  logic              wr_mode;

  assign pready  = 1'b1;
  assign wr_mode = psel && penable && pwrite && (paddr[2] == REG_MODE);
  assign clear_o = wr_mode;
  assign mode_d  = wr_mode ? pwdata[MODE_W-1:0] : mode_q;
  assign mode_o  = mode_q;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MODE) begin
      prdata[MODE_W-1:0] = mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else begin
      mode_q <= mode_d;
    end
  end

endmodule

// ===== sv/mwrle_parser.sv =====
// Byte parser: header, run and literal tracking plus pixel assembly.
module mwrle_parser import mwrle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              start_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic              clear_i,
  output res_t              res_o
);

  phase_e      phase_q, phase_d, phase_w;
  logic [7:0]  lit_q, lit_d, lit_w, lit_dec;
  logic [7:0]  run_q, run_d, run_w;
  logic [1:0]  idx_q, idx_d, idx_w;
  logic [15:0] part_q, part_d, part_w;
  logic [2:0]  bpp;
  logic [2:0]  idx_next;
  logic        headed;
  logic        active;
  pixel_t      full_pix;

  assign active  = fire_i && (mode_i <= MODE_W'(MODE_RLE24));
  assign lit_dec = lit_w - 8'd1;

  always_comb begin
    // a section start clears the parser before the byte is taken
    if (start_i) begin
      phase_w = PH_HEADER;
      lit_w   = '0;
      run_w   = '0;
      idx_w   = '0;
      part_w  = '0;
    end else begin
      phase_w = phase_q;
      lit_w   = lit_q;
      run_w   = run_q;
      idx_w   = idx_q;
      part_w  = part_q;
    end
  end

  always_comb begin
    unique case (mode_i)
      MODE_RLE16: bpp = 3'd2;
      MODE_RLE24: bpp = 3'd3;
      default:    bpp = 3'd1;
    endcase
  end

  assign idx_next = {1'b0, idx_w} + 3'd1;
  assign headed   = (mode_i == MODE_RLE8) || (mode_i == MODE_RLE16) ||
                    (mode_i == MODE_RLE24);

  always_comb begin
    unique case (idx_w)
      2'd0:    full_pix = {16'h0000, byte_i};
      2'd1:    full_pix = {8'h00, byte_i, part_w[7:0]};
      2'd2:    full_pix = {byte_i, part_w};
      default: full_pix = {8'h00, part_w};
    endcase
  end

  always_comb begin
    phase_d       = phase_w;
    lit_d         = lit_w;
    run_d         = run_w;
    idx_d         = idx_w;
    part_d        = part_w;
    res_o.valid   = 1'b0;
    res_o.pixel   = full_pix;
    res_o.count   = 8'd1;
    if (mode_i == MODE_RAW) begin
      res_o.valid = 1'b1;
      res_o.pixel = {16'h0000, byte_i};
    end else if (mode_i == MODE_RLE12) begin
      if (idx_w == 2'd0) begin
        part_d = {8'h00, byte_i};
        idx_d  = 2'd1;
      end else begin
        idx_d       = '0;
        part_d      = '0;
        res_o.valid = 1'b1;
        res_o.pixel = {scale17(part_w[3:0]), scale17(part_w[7:4]),
                       scale17(byte_i[3:0])};
        res_o.count = {4'h0, byte_i[7:4]} + 8'd1;
      end
    end else if (headed) begin
      if ((phase_w != PH_RUN) && (phase_w != PH_LITERAL)) begin
        if (byte_i <= RUN_HDR_MAX) begin
          run_d   = byte_i + 8'd1;
          phase_d = PH_RUN;
        end else begin
          lit_d   = 8'd0 - byte_i;
          phase_d = PH_LITERAL;
        end
        idx_d  = '0;
        part_d = '0;
      end else if (idx_next < bpp) begin
        // gather bytes of a multi-byte pixel
        unique case (idx_w)
          2'd0:    part_d = {part_w[15:8], part_w[7:0] | byte_i};
          2'd1:    part_d = {part_w[15:8] | byte_i, part_w[7:0]};
          default: part_d = part_w;
        endcase
        idx_d = idx_next[1:0];
      end else begin
        idx_d       = '0;
        part_d      = '0;
        res_o.valid = 1'b1;
        if (phase_w == PH_RUN) begin
          res_o.count = run_w;
          run_d       = '0;
          phase_d     = PH_HEADER;
        end else begin
          lit_d = lit_dec;
          if (lit_dec == 8'd0) begin
            phase_d = PH_HEADER;
          end
        end
      end
    end
    // unused modes leave everything untouched
    if (!active) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      lit_q   <= '0;
      run_q   <= '0;
      idx_q   <= '0;
      part_q  <= '0;
    end else if (clear_i) begin
      phase_q <= PH_HEADER;
      lit_q   <= '0;
      run_q   <= '0;
      idx_q   <= '0;
      part_q  <= '0;
    end else if (active) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      run_q   <= run_d;
      idx_q   <= idx_d;
      part_q  <= part_d;
    end
  end

`ifndef SYNTHESIS
  a_lit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LITERAL) |-> (lit_q != 8'd0))
    else $error("literal phase with no literals left");

  a_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RUN) |-> ((run_q != 8'd0) && (run_q <= 8'd128)))
    else $error("pending run count out of range");

  a_rle8_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_i == MODE_RLE8) |-> (idx_q == 2'd0))
    else $error("byte index moved in single-byte mode");
`endif

endmodule

// ===== sv/mwrle_outbuf.sv =====
// Result register with one skid entry behind it.
module mwrle_outbuf import mwrle_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  res_t   res_i,
  output logic   skid_full_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output pixel_t pixel_value_o,
  output count_t repeat_count_o
);

  logic   out_valid_q, out_valid_d;
  logic   skid_valid_q, skid_valid_d;
  pixel_t out_pix_q, out_pix_d, skid_pix_q, skid_pix_d;
  count_t out_cnt_q, out_cnt_d, skid_cnt_q, skid_cnt_d;
  logic   pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_pix_d    = out_pix_q;
    out_cnt_d    = out_cnt_q;
    skid_pix_d   = skid_pix_q;
    skid_cnt_d   = skid_cnt_q;
    if (skid_valid_q) begin
      // no new item arrives while the skid entry is full
      if (pop) begin
        out_pix_d    = skid_pix_q;
        out_cnt_d    = skid_cnt_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_i.valid) begin
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_pix_d   = res_i.pixel;
        out_cnt_d   = res_i.count;
      end else begin
        skid_valid_d = 1'b1;
        skid_pix_d   = res_i.pixel;
        skid_cnt_d   = res_i.count;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q  <= out_pix_d;
    out_cnt_q  <= out_cnt_d;
    skid_pix_q <= skid_pix_d;
    skid_cnt_q <= skid_cnt_d;
  end

  assign skid_full_o    = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_pix_q;
  assign repeat_count_o = out_cnt_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in front");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> !skid_valid_q)
    else $error("result offered while skid entry full");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry not moved forward on pop");
`endif

endmodule

// ===== sv/multi_width_rle_pixel_decoder.sv =====
// Top level of the multi-width run-length pixel decoder.
//
//  channel   direction  handshake               payload
//  input     in         in_valid_i/in_stall_o   data_byte_i, section_start_i
//  result    out        out_valid_o/out_stall_i pixel_value_o, repeat_count_o
//  config    in         psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// One byte per cycle while in_stall_o is low; an accepted byte is held in the
// input register, and its result is registered in the result or skid entry.
// Path: input register, parser logic, result register with a skid entry.
// Reset gives mode RLE8 and an empty parser; no clearing pass is needed.
// A stalled result plus one in the skid entry hold off new bytes.
module multi_width_rle_pixel_decoder import mwrle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               section_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [23:0]        pixel_value_o,
  output logic [7:0]         repeat_count_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        byte_q, byte_d;
  logic              start_q, start_d;
  logic              skid_full;
  logic              fire;
  logic [MODE_W-1:0] mode;
  logic              clear;
  res_t              res;

  assign fire       = in_valid_q && !skid_full;
  assign in_stall_o = in_valid_q && skid_full;

  always_comb begin
    in_valid_d = in_valid_q;
    byte_d     = byte_q;
    start_d    = start_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
      byte_d     = data_byte_i;
      start_d    = section_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    start_q <= start_d;
  end

  mwrle_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode),
    .clear_o (clear)
  );

  mwrle_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (byte_q),
    .start_i (start_q),
    .mode_i  (mode),
    .clear_i (clear),
    .res_o   (res)
  );

  mwrle_outbuf u_outbuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res),
    .skid_full_o    (skid_full),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o)
  );

endmodule
